/* sv/bfd_pkg.sv */
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types, constants and codes for the blockwise frame delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfd_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned QUEUE_DEPTH_DEF = 71;
  localparam int unsigned MAX_WIDTH_DEF   = 64;
  localparam int unsigned MAX_HEIGHT_DEF  = 64;
  localparam int unsigned PIXEL_BITS_DEF  = 32;

  // Fixed field widths
  localparam int unsigned DATA_W     = 32;  // pixel ports
  localparam int unsigned DIM_W      = 7;   // frame width / height, raster position
  localparam int unsigned BS_W       = 5;   // block size
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DELAY_W    = 7;   // slot offset, holds up to 127
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned ROOT_W     = 16;  // square root working width

  typedef enum logic [MODE_W-1:0] {
    MODE_VSTRIPE = 2'd0,
    MODE_HSTRIPE = 2'd1,
    MODE_RINGS   = 2'd2,
    MODE_NONE    = 2'd3
  } delay_mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_BLOCK  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_e;

  // Register reset values
  localparam delay_mode_e      RST_MODE   = MODE_RINGS;
  localparam logic [BS_W-1:0]  RST_BLOCK  = 5'd2;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 7'd64;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ACCESS,
    ST_REPLY
  } top_state_e;

  typedef enum logic [2:0] {
    DL_IDLE,
    DL_DIV,
    DL_GRID,
    DL_SQUARE,
    DL_ROOT,
    DL_FINISH
  } dly_state_e;

  // Job handed to the delay unit for one pixel
  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic [BS_W-1:0]  bs;
    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
    delay_mode_e      mode;
  } dly_job_t;

  // Outcome of the delay calculation
  typedef struct packed {
    logic               in_grid;
    logic [DELAY_W-1:0] delay;
  } dly_res_t;

  function automatic logic [DIM_W-1:0] absdiff(logic [DIM_W-1:0] a, logic [DIM_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* sv/bfd_frame_store.sv */
// ----------------------------------------------------------------------------
// bfd_frame_store
// Single-clock frame ring memory: one write and one registered read port,
// with a zeroing sweep over every entry after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfd_frame_store #(
  parameter int unsigned DEPTH  = 290816,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  output logic              ready_o
);

  logic [DATA_W-1:0] store_mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              clr_busy_q, clr_busy_d;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // Clearing sweep, one entry a cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Write port shared between sweep and user
  assign mem_we    = clr_busy_q | wr_en_i;
  assign mem_waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= store_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clr_busy_q;

  // No user access until the sweep is through
  a_no_access_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !wr_en_i && !rd_en_i)
    else $error("frame store accessed during clearing sweep");

  // Read and write of one beat never hit the same entry
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && wr_en_i |-> rd_addr_i != wr_addr_i)
    else $error("frame store read and write to the same entry");

  // Sweep ends only after the last entry
  a_sweep_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> $past(clr_addr_q) == ADDR_W'(DEPTH - 1))
    else $error("clearing sweep ended early");

endmodule

/* sv/bfd_delay_unit.sv */
// ----------------------------------------------------------------------------
// bfd_delay_unit
// Works out the per-block delay of one pixel: four bit-serial dividers for the
// block coordinates and grid size, then an optional iterative square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfd_delay_unit #(
  parameter int unsigned QUEUE_DEPTH = bfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bfd_pkg::dly_job_t job_i,
  output logic              done_o,
  output bfd_pkg::dly_res_t res_o
);

  import bfd_pkg::*;

  localparam int unsigned LANES    = 4;
  localparam int unsigned LANE_COL = 0;
  localparam int unsigned LANE_ROW = 1;
  localparam int unsigned LANE_GW  = 2;
  localparam int unsigned LANE_GH  = 3;
  localparam int unsigned STEP_W   = $clog2(DIM_W);
  localparam int unsigned V_W      = DIM_W + 1;

  dly_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIM_W-1:0]  dvd_q [LANES];
  logic [DIM_W-1:0]  dvd_d [LANES];
  logic [BS_W-1:0]   rem_q [LANES];
  logic [BS_W-1:0]   rem_d [LANES];
  logic [BS_W-1:0]   bs_q;
  delay_mode_e       mode_q;
  logic [DIM_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic              grid_q, grid_d;
  logic [ROOT_W-1:0] n_q, n_d, root_q, root_d, bit_q, bit_d;
  logic [V_W-1:0]    v;
  logic [DELAY_W-1:0] half;

  // Sequencer and datapath next values
  always_comb begin
    logic [BS_W:0]     shifted;
    logic [ROOT_W-1:0] trial;
    state_d = state_q;
    step_d  = step_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    grid_d  = grid_q;
    n_d     = n_q;
    root_d  = root_q;
    bit_d   = bit_q;
    shifted = '0;
    trial   = '0;
    for (int i = 0; i < LANES; i++) begin
      dvd_d[i] = dvd_q[i];
      rem_d[i] = rem_q[i];
    end

    unique case (state_q)
      DL_IDLE: begin
        if (start_i) begin
          dvd_d[LANE_COL] = job_i.col;
          dvd_d[LANE_ROW] = job_i.row;
          dvd_d[LANE_GW]  = job_i.fw;
          dvd_d[LANE_GH]  = job_i.fh;
          for (int i = 0; i < LANES; i++) begin
            rem_d[i] = '0;
          end
          step_d  = '0;
          state_d = DL_DIV;
        end
      end
      DL_DIV: begin
        // one restoring step per lane; quotient bits shift into the dividend
        for (int i = 0; i < LANES; i++) begin
          shifted = {rem_q[i], dvd_q[i][DIM_W-1]};
          if (shifted >= {1'b0, bs_q}) begin
            rem_d[i] = BS_W'(shifted - {1'b0, bs_q});
            dvd_d[i] = {dvd_q[i][DIM_W-2:0], 1'b1};
          end else begin
            rem_d[i] = BS_W'(shifted);
            dvd_d[i] = {dvd_q[i][DIM_W-2:0], 1'b0};
          end
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIM_W - 1)) begin
          state_d = DL_GRID;
        end
      end
      DL_GRID: begin
        dx_d    = absdiff(dvd_q[LANE_COL], dvd_q[LANE_GW] >> 1);
        dy_d    = absdiff(dvd_q[LANE_ROW], dvd_q[LANE_GH] >> 1);
        grid_d  = (dvd_q[LANE_COL] < dvd_q[LANE_GW]) && (dvd_q[LANE_ROW] < dvd_q[LANE_GH]);
        state_d = (mode_q == MODE_RINGS) ? DL_SQUARE : DL_FINISH;
      end
      DL_SQUARE: begin
        n_d     = ROOT_W'(dx_q) * ROOT_W'(dx_q) + ROOT_W'(dy_q) * ROOT_W'(dy_q);
        root_d  = '0;
        bit_d   = ROOT_W'(1) << (ROOT_W - 2);
        state_d = DL_ROOT;
      end
      DL_ROOT: begin
        // two radicand bits per step
        trial = root_q + bit_q;
        if (n_q >= trial) begin
          n_d    = n_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = DL_FINISH;
        end
      end
      DL_FINISH: begin
        state_d = DL_IDLE;
      end
      default: begin
        state_d = DL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DL_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      dvd_q[i] <= dvd_d[i];
      rem_q[i] <= rem_d[i];
    end
    if (state_q == DL_IDLE && start_i) begin
      bs_q   <= job_i.bs;
      mode_q <= job_i.mode;
    end
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    grid_q <= grid_d;
    n_q    <= n_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  // Raw delay by mode, then halve and clamp to the ring
  always_comb begin
    unique case (mode_q)
      MODE_VSTRIPE: v = {1'b0, dx_q};
      MODE_HSTRIPE: v = {1'b0, dy_q};
      MODE_RINGS:   v = V_W'(root_q);
      MODE_NONE:    v = '0;
      default:      v = '0;
    endcase
  end

  assign half          = DELAY_W'(v >> 1);
  assign res_o.in_grid = grid_q;
  assign res_o.delay   = (32'(half) > QUEUE_DEPTH - 1) ? DELAY_W'(QUEUE_DEPTH - 1) : half;
  assign done_o        = (state_q == DL_FINISH);

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == DL_IDLE)
    else $error("delay unit started while busy");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == DL_DIV && step_q == STEP_W'(DIM_W - 1) |=> state_q == DL_GRID)
    else $error("divider did not finish after its last step");

  a_delay_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 32'(res_o.delay) <= QUEUE_DEPTH - 1)
    else $error("delay beyond ring depth");

endmodule

/* sv/blockwise_frame_delay_top.sv */
// ----------------------------------------------------------------------------
// blockwise_frame_delay_top
// Blockwise frame delay: pixel ring store, raster tracking, configuration.
// ----------------------------------------------------------------------------
// Each accepted pixel is written to the current ring slot and answered with the
// pixel at the same position from an older slot, chosen per square block by the
// delay mode. Per pixel, bit-serial dividers work out the block coordinates,
// in ring mode the square root of the ring distance follows, then come one
// memory access and the load of the output register, which waits while the
// output is held. A new pixel is accepted only after the last one is loaded.
// A finished pixel waits in the output register while the next one is worked
// on. After reset the frame store is zeroed one entry a cycle, over all
// QUEUE_DEPTH*MAX_HEIGHT*MAX_WIDTH entries (290816 by default); no pixel is
// accepted until then, while configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blockwise_frame_delay_top #(
  parameter int unsigned QUEUE_DEPTH = bfd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_WIDTH   = bfd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = bfd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned PIXEL_BITS  = bfd_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bfd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bfd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bfd_pkg::DATA_W-1:0]     pixel_in_i,
  input  logic                           start_of_frame_i,
  // pixel output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bfd_pkg::DATA_W-1:0]     pixel_out_o
);

  import bfd_pkg::*;

  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
  localparam int unsigned STORE_DEPTH = QUEUE_DEPTH * MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned SUM_W       = DELAY_W + 1;

  // Configuration registers
  delay_mode_e      delay_mode_q;
  logic [BS_W-1:0]  block_size_q;
  logic [DIM_W-1:0] frame_width_q, frame_height_q;
  logic             cfg_we;

  // Raster and ring state
  top_state_e       state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_nx;
  logic [COL_W-1:0] col_q, col_cur;
  logic [ROW_W-1:0] row_q, row_cur;
  logic             col_wrap, row_wrap;
  logic [COL_W-1:0] item_col_q;
  logic [ROW_W-1:0] item_row_q;
  logic [PIXEL_BITS-1:0] item_pix_q;
  logic             in_acc;

  // Effective sizes
  logic [BS_W-1:0]  bs_eff;
  logic [DIM_W-1:0] fw_eff, fh_eff;

  // Delay unit link
  dly_job_t         job;
  dly_res_t         dly_res, dly_res_q;
  logic             dly_done;

  // Store link
  logic              store_rdy;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [SUM_W-1:0]  slot_sum, rd_slot8;
  logic [PIXEL_BITS-1:0] rd_data, result;

  // Output register
  logic              out_valid_q;
  logic [DATA_W-1:0] pixel_out_q;
  logic              out_load;

  function automatic logic [ADDR_W-1:0] store_addr(logic [SLOT_W-1:0] s,
                                                   logic [ROW_W-1:0]  r,
                                                   logic [COL_W-1:0]  c);
    return ADDR_W'(s) * ADDR_W'(MAX_HEIGHT * MAX_WIDTH)
         + ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

  // APB register file
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_mode_q   <= RST_MODE;
      block_size_q   <= RST_BLOCK;
      frame_width_q  <= RST_WIDTH;
      frame_height_q <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_MODE:   delay_mode_q   <= delay_mode_e'(pwdata[MODE_W-1:0]);
        REG_BLOCK:  block_size_q   <= pwdata[BS_W-1:0];
        REG_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_MODE:   prdata = APB_DATA_W'(delay_mode_q);
      REG_BLOCK:  prdata = APB_DATA_W'(block_size_q);
      REG_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
      REG_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
      default:    prdata = '0;
    endcase
  end

  // Zero sizes count as one, oversize clamps to the store
  assign bs_eff = (block_size_q == '0) ? BS_W'(1) : block_size_q;
  assign fw_eff = (frame_width_q == '0) ? DIM_W'(1)
                : ((32'(frame_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : frame_width_q);
  assign fh_eff = (frame_height_q == '0) ? DIM_W'(1)
                : ((32'(frame_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : frame_height_q);

  // Frame start steps the ring down and restarts the raster
  assign in_acc  = in_valid_i & in_ready_o;
  assign col_cur = start_of_frame_i ? '0 : col_q;
  assign row_cur = start_of_frame_i ? '0 : row_q;
  assign slot_nx = !start_of_frame_i ? slot_q
                 : ((slot_q == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : slot_q - 1'b1);
  assign col_wrap = (32'(col_cur) + 32'd1 >= 32'(fw_eff)) || (32'(col_cur) + 32'd1 >= MAX_WIDTH);
  assign row_wrap = (32'(row_cur) + 32'd1 >= 32'(fh_eff)) || (32'(row_cur) + 32'd1 >= MAX_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (in_acc) begin
      slot_q <= slot_nx;
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_cur + 1'b1;
      end else begin
        col_q <= col_cur + 1'b1;
        row_q <= row_cur;
      end
    end
  end

  // Per-beat payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_col_q <= col_cur;
      item_row_q <= row_cur;
      item_pix_q <= pixel_in_i[PIXEL_BITS-1:0];
    end
    if (state_q == ST_CALC && dly_done) begin
      dly_res_q <= dly_res;
    end
  end

  // Delay calculation
  assign job.col  = DIM_W'(col_cur);
  assign job.row  = DIM_W'(row_cur);
  assign job.bs   = bs_eff;
  assign job.fw   = fw_eff;
  assign job.fh   = fh_eff;
  assign job.mode = delay_mode_q;

  bfd_delay_unit #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_delay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .job_i   (job),
    .done_o  (dly_done),
    .res_o   (dly_res)
  );

  // Slot holding the delayed frame
  assign slot_sum = SUM_W'(slot_q) + SUM_W'(dly_res_q.delay);
  assign rd_slot8 = (32'(slot_sum) >= QUEUE_DEPTH) ? slot_sum - SUM_W'(QUEUE_DEPTH) : slot_sum;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (dly_done) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        wr_en   = 1'b1;
        rd_en   = dly_res_q.in_grid && (dly_res_q.delay != '0);
        state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && store_rdy;
  assign wr_addr    = store_addr(slot_q, item_row_q, item_col_q);
  assign rd_addr    = store_addr(SLOT_W'(rd_slot8), item_row_q, item_col_q);

  bfd_frame_store #(
    .DEPTH  (STORE_DEPTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (item_pix_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .ready_o   (store_rdy)
  );

  // Zero off the grid, incoming pixel on zero delay, else the stored one
  assign result = !dly_res_q.in_grid ? '0
                : ((dly_res_q.delay == '0) ? item_pix_q : rd_data);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_out_q <= DATA_W'(result);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;

  a_accept_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_CALC)
    else $error("accepted beat did not start a calculation");

  a_slot_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < QUEUE_DEPTH)
    else $error("ring slot out of range");

  a_reply_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REPLY && out_valid_q && !out_ready_i |=> state_q == ST_REPLY)
    else $error("result dropped over a pending output beat");

endmodule
